[rtl/psd_pkg.sv]
`default_nettype none

package psd_pkg;

  localparam int unsigned CoordWidthDef = 16;

  // fixed prep depth: differences, products, sums, square and select
  localparam int unsigned PrepStages = 4;

endpackage

`default_nettype wire

[rtl/psd_in_if.sv]
`default_nettype none

interface psd_in_if import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] end1_x;
  logic signed [COORD_WIDTH-1:0] end1_y;
  logic signed [COORD_WIDTH-1:0] end2_x;
  logic signed [COORD_WIDTH-1:0] end2_y;

  modport source (
    output valid, point_x, point_y, end1_x, end1_y, end2_x, end2_y,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, end1_x, end1_y, end2_x, end2_y,
    output ready
  );

endinterface

`default_nettype wire

[rtl/psd_out_if.sv]
`default_nettype none

interface psd_out_if import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) ();

  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH:0]   seg_distance;

  modport source (
    output valid, seg_distance,
    input  ready
  );

  modport sink (
    input  valid, seg_distance,
    output ready
  );

endinterface

`default_nettype wire

[rtl/psd_prep.sv]
`default_nettype none

module psd_prep import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  localparam int unsigned MagW = 2 * COORD_WIDTH + 1,
  localparam int unsigned NumW = 2 * MagW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end1_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end1_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end2_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end2_y_i,
  output logic                               valid_o,
  output logic [NumW-1:0]                    num_o,
  output logic [MagW-1:0]                    den_o
);

  localparam int unsigned DiffW = COORD_WIDTH + 1;
  localparam int unsigned ProdW = 2 * COORD_WIDTH + 2;
  localparam int unsigned SumW  = 2 * COORD_WIDTH + 3;

  logic [PrepStages-1:0] valid_q;

  // stage 1: differences
  logic signed [DiffW-1:0] dx_q, dy_q, wx_q, wy_q, vx_q, vy_q;
  // stage 2: products
  logic signed [ProdW-1:0] dxdx_q, dydy_q, dxwx_q, dywy_q, dxvx_q, dyvy_q;
  logic signed [ProdW-1:0] dxwy_q, dywx_q, wxwx_q, wywy_q, vxvx_q, vyvy_q;
  // stage 3: sums and tests
  logic signed [SumW-1:0] dd_s, dw_s, dv_s, cr_s, cr_neg_s, ww_s, vv_s, cr_abs_s;
  logic                   on_d, on_q;
  logic [MagW-1:0]        dd_q, cr_q, ww_q, vv_q;
  // stage 4: square and select
  logic [NumW-1:0]        sq_s, num_d, num_q;
  logic [MagW-1:0]        mn_s, den_d, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[PrepStages-2:0], valid_i};
    end
  end

  assign dd_s     = SumW'(dxdx_q) + SumW'(dydy_q);
  assign dw_s     = SumW'(dxwx_q) + SumW'(dywy_q);
  assign dv_s     = SumW'(dxvx_q) + SumW'(dyvy_q);
  assign cr_s     = SumW'(dxwy_q) - SumW'(dywx_q);
  assign cr_neg_s = -cr_s;
  assign cr_abs_s = cr_s[SumW-1] ? cr_neg_s : cr_s;
  assign ww_s     = SumW'(wxwx_q) + SumW'(wywy_q);
  assign vv_s     = SumW'(vxvx_q) + SumW'(vyvy_q);
  assign on_d     = (dd_s != '0) && !dw_s[SumW-1] && (dv_s[SumW-1] || (dv_s == '0));

  assign sq_s  = NumW'(cr_q) * NumW'(cr_q);
  assign mn_s  = (ww_q < vv_q) ? ww_q : vv_q;
  assign num_d = on_q ? sq_s : NumW'(mn_s);
  assign den_d = on_q ? dd_q : MagW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= DiffW'(end2_x_i) - DiffW'(end1_x_i);
      dy_q <= DiffW'(end2_y_i) - DiffW'(end1_y_i);
      wx_q <= DiffW'(point_x_i) - DiffW'(end1_x_i);
      wy_q <= DiffW'(point_y_i) - DiffW'(end1_y_i);
      vx_q <= DiffW'(point_x_i) - DiffW'(end2_x_i);
      vy_q <= DiffW'(point_y_i) - DiffW'(end2_y_i);

      dxdx_q <= ProdW'(dx_q) * ProdW'(dx_q);
      dydy_q <= ProdW'(dy_q) * ProdW'(dy_q);
      dxwx_q <= ProdW'(dx_q) * ProdW'(wx_q);
      dywy_q <= ProdW'(dy_q) * ProdW'(wy_q);
      dxvx_q <= ProdW'(dx_q) * ProdW'(vx_q);
      dyvy_q <= ProdW'(dy_q) * ProdW'(vy_q);
      dxwy_q <= ProdW'(dx_q) * ProdW'(wy_q);
      dywx_q <= ProdW'(dy_q) * ProdW'(wx_q);
      wxwx_q <= ProdW'(wx_q) * ProdW'(wx_q);
      wywy_q <= ProdW'(wy_q) * ProdW'(wy_q);
      vxvx_q <= ProdW'(vx_q) * ProdW'(vx_q);
      vyvy_q <= ProdW'(vy_q) * ProdW'(vy_q);

      on_q <= on_d;
      dd_q <= dd_s[MagW-1:0];
      cr_q <= cr_abs_s[MagW-1:0];
      ww_q <= ww_s[MagW-1:0];
      vv_q <= vv_s[MagW-1:0];

      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign valid_o = valid_q[PrepStages-1];
  assign num_o   = num_q;
  assign den_o   = den_q;

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> den_o != '0)
    else $error("divisor is zero on a valid beat");

endmodule

`default_nettype wire

[rtl/psd_div.sv]
`default_nettype none

module psd_div import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  localparam int unsigned MagW = 2 * COORD_WIDTH + 1,
  localparam int unsigned NumW = 2 * MagW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [MagW-1:0] den_i,
  output logic                 valid_o,
  output logic [MagW-1:0]      quot_o
);

  // quotient is known to fit MagW bits, one quotient bit per stage
  localparam int unsigned QuotW = MagW;

  logic            valid_q [QuotW+1];
  logic [MagW-1:0] rem_q   [QuotW+1];
  logic [QuotW-1:0] nq_q   [QuotW+1];
  logic [MagW-1:0] den_q   [QuotW+1];

  assign valid_q[0] = valid_i;
  assign rem_q[0]   = num_i[NumW-1:QuotW];
  assign nq_q[0]    = num_i[QuotW-1:0];
  assign den_q[0]   = den_i;

  for (genvar i = 0; i < QuotW; i++) begin : g_stage
    logic [MagW:0] trial;
    logic [MagW:0] diff;
    logic          take;

    assign trial = {rem_q[i], nq_q[i][QuotW-1]};
    assign diff  = trial - (MagW+1)'(den_q[i]);
    assign take  = trial >= (MagW+1)'(den_q[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= take ? diff[MagW-1:0] : trial[MagW-1:0];
        nq_q[i+1]  <= {nq_q[i][QuotW-2:0], take};
        den_q[i+1] <= den_q[i];
      end
    end
  end

  assign valid_o = valid_q[QuotW];
  assign quot_o  = nq_q[QuotW];

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rem_q[QuotW] < den_q[QuotW])
    else $error("division remainder not below divisor");

endmodule

`default_nettype wire

[rtl/psd_sqrt.sv]
`default_nettype none

module psd_sqrt import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  localparam int unsigned MagW = 2 * COORD_WIDTH + 1,
  localparam int unsigned RootW = COORD_WIDTH + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [MagW-1:0]  rad_i,
  output logic                  valid_o,
  output logic [RootW-1:0]      root_o
);

  localparam int unsigned TrialW = MagW + 2;

  logic             valid_q [RootW+1];
  logic [MagW-1:0]  rem_q   [RootW+1];
  logic [RootW-1:0] root_q  [RootW+1];

  assign valid_q[0] = valid_i;
  assign rem_q[0]   = rad_i;
  assign root_q[0]  = '0;

  // stage j settles root bit COORD_WIDTH - j
  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int unsigned Bit = COORD_WIDTH - j;
    logic [TrialW-1:0] trial;
    logic [TrialW-1:0] rem_ext;
    logic              take;

    assign trial   = (TrialW'(root_q[j]) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
    assign rem_ext = TrialW'(rem_q[j]);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[j+1] <= valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= take ? MagW'(rem_ext - trial) : rem_q[j];
        root_q[j+1] <= take ? (root_q[j] | (RootW'(1) << Bit)) : root_q[j];
      end
    end
  end

  assign valid_o = valid_q[RootW];
  assign root_o  = root_q[RootW];

  a_root_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (TrialW'(rem_q[RootW]) <= (TrialW'(root_q[RootW]) << 1)))
    else $error("square root remainder exceeds twice the root");

endmodule

`default_nettype wire

[rtl/point_segment_distance.sv]
// Point to segment distance. Each beat on req_i carries a query point and the two
// endpoints of a segment as signed fixed-point coordinates with 4 fraction bits; the
// matching beat on rsp_o gives the Euclidean distance, same fraction bits, rounded
// down. If the foot of the point lies on the segment (ends included) the distance is
// the perpendicular one, otherwise the nearer endpoint's; a zero-length segment gives
// the distance to the first endpoint. One beat is taken every clock; the pipeline is
// built of differences, products, sums and squaring, then a restoring divider and a
// square root that each resolve one result bit per pipeline stage. While an output
// beat waits on rsp_o.ready the whole pipeline holds and req_i.ready is low.
`default_nettype none

module point_segment_distance import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psd_in_if.sink      req_i,
  psd_out_if.source   rsp_o
);

  localparam int unsigned MagW  = 2 * COORD_WIDTH + 1;
  localparam int unsigned NumW  = 2 * MagW;
  localparam int unsigned RootW = COORD_WIDTH + 1;

  logic            en;
  logic            prep_valid;
  logic [NumW-1:0] prep_num;
  logic [MagW-1:0] prep_den;
  logic            div_valid;
  logic [MagW-1:0] div_quot;
  logic            sqrt_valid;
  logic [RootW-1:0] sqrt_root;

  assign en          = !sqrt_valid || rsp_o.ready;
  assign req_i.ready = en;

  psd_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (req_i.valid),
    .point_x_i (req_i.point_x),
    .point_y_i (req_i.point_y),
    .end1_x_i  (req_i.end1_x),
    .end1_y_i  (req_i.end1_y),
    .end2_x_i  (req_i.end2_x),
    .end2_y_i  (req_i.end2_y),
    .valid_o   (prep_valid),
    .num_o     (prep_num),
    .den_o     (prep_den)
  );

  psd_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .num_i   (prep_num),
    .den_i   (prep_den),
    .valid_o (div_valid),
    .quot_o  (div_quot)
  );

  psd_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .rad_i   (div_quot),
    .valid_o (sqrt_valid),
    .root_o  (sqrt_root)
  );

  assign rsp_o.valid        = sqrt_valid;
  assign rsp_o.seg_distance = sqrt_root;

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sqrt_root) && sqrt_valid)
    else $error("output beat changed while the pipeline was held");

endmodule

`default_nettype wire

[test/point_segment_distance_tb.sv]
`timescale 1ns / 100ps

module point_segment_distance_tb;
  import psd_pkg::*;

  localparam int unsigned CW = CoordWidthDef;
  localparam int unsigned LATENCY = 3 * CW + 6;
  localparam longint CycleLimit = 400000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW:0] dist_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  psd_in_if #(.COORD_WIDTH(CW)) req_if ();
  psd_out_if #(.COORD_WIDTH(CW)) rsp_if ();

  point_segment_distance #(.COORD_WIDTH(CW)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #10 clk_i = ~clk_i;

  dist_t expected_dist_q[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_on_seg = 0;
  longint cycles = 0;
  int unsigned burst_left = 0;

  // largest r with r*r*den <= num
  function automatic longint unsigned isqrt_ratio(logic [191:0] num, logic [191:0] den);
    longint unsigned r;
    logic [191:0] t;
    r = 0;
    for (int k = CW + 2; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t * den <= num) r = r | (64'd1 << k);
    end
    return r;
  endfunction

  function automatic dist_t seg_dist(coord_t px, coord_t py, coord_t ax, coord_t ay,
                                     coord_t bx, coord_t by, output bit on_seg);
    logic signed [191:0] dx, dy, wx, wy, vx, vy, dd, dw, dv, cr;
    longint unsigned r1, r2;
    dx = 192'(signed'(bx)) - 192'(signed'(ax));
    dy = 192'(signed'(by)) - 192'(signed'(ay));
    wx = 192'(signed'(px)) - 192'(signed'(ax));
    wy = 192'(signed'(py)) - 192'(signed'(ay));
    vx = 192'(signed'(px)) - 192'(signed'(bx));
    vy = 192'(signed'(py)) - 192'(signed'(by));
    dd = dx * dx + dy * dy;
    dw = dx * wx + dy * wy;
    dv = dx * vx + dy * vy;
    on_seg = (dd != 0) && (dw >= 0) && (dv <= 0);
    if (on_seg) begin
      cr = dx * wy - dy * wx;
      if (cr < 0) cr = -cr;
      return dist_t'(isqrt_ratio(cr * cr, dd));
    end
    r1 = isqrt_ratio(wx * wx + wy * wy, 192'd1);
    r2 = isqrt_ratio(vx * vx + vy * vy, 192'd1);
    return dist_t'((r1 < r2) ? r1 : r2);
  endfunction

  task automatic report_mismatch(string what, dist_t got, dist_t exp);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
  endtask

  // one beat on the request side, with bursty gaps
  task automatic send_query(coord_t px, coord_t py, coord_t ax, coord_t ay,
                            coord_t bx, coord_t by);
    bit on_seg;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    expected_dist_q.push_back(seg_dist(px, py, ax, ay, bx, by, on_seg));
    if (on_seg) n_on_seg++;
    req_if.valid <= 1'b1;
    req_if.point_x <= px;
    req_if.point_y <= py;
    req_if.end1_x <= ax;
    req_if.end1_y <= ay;
    req_if.end2_x <= bx;
    req_if.end2_y <= by;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
    if ($urandom_range(0, 9) == 0) burst_left = 0;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(int'($urandom_range(0, 63)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    coord_t mn, mx;
    mn = coord_t'(-32768);
    mx = coord_t'(32767);
    send_query(0, 0, 0, 0, 0, 0);
    send_query(mx, mx, mn, mn, mn, mn);
    send_query(mn, mn, mx, mx, mx, mx);
    send_query(mn, mx, mn, mn, mx, mx);
    send_query(mx, mn, mn, mn, mx, mx);
    send_query(mn, mn, mx, mn, mx, mx);
    send_query(mx, mx, mn, mx, mn, mn);
    send_query(16, 32, 0, 0, 32, 0);
    send_query(0, 32, 0, 0, 32, 0);
    send_query(32, 32, 0, 0, 32, 0);
    send_query(48, 32, 0, 0, 32, 0);
    send_query(-16, -16, 0, 0, 32, 32);
    send_query(5, 7, 5, 7, 100, -3);
    send_query(100, -3, 5, 7, 100, -3);
    send_query(-1, -1, -1, -1, -1, -1);
    send_query(coord_t'(16'h5555), coord_t'(16'haaaa), coord_t'(16'haaaa),
               coord_t'(16'h5555), coord_t'(16'h5555), coord_t'(16'h5555));
    send_query(17, -9, 3, 3, -40, 25);
    send_query(mx, 0, mn, 0, mx, 0);
  endtask

  task automatic test_random_segments();
    coord_t ax, ay, bx, by, px, py;
    int t;
    for (int i = 0; i < 600; i++) begin
      ax = rand_coord();
      ay = rand_coord();
      bx = rand_coord();
      by = rand_coord();
      px = rand_coord();
      py = rand_coord();
      // point near the midpoint, to aim the foot at the segment
      if ($urandom_range(0, 2) == 0) begin
        t = $urandom_range(0, 200) - 100;
        px = coord_t'((int'(ax) + int'(bx)) / 2 + t);
        py = coord_t'((int'(ay) + int'(by)) / 2 - t);
      end
      if ($urandom_range(0, 19) == 0) begin
        bx = ax;
        by = ay;
      end
      send_query(px, py, ax, ay, bx, by);
    end
  endtask

  // response stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if ((cycles % 500) < 150) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_dist_q.size() == 0) begin
        report_mismatch("unexpected beat", rsp_if.seg_distance, '0);
      end else begin
        dist_t exp;
        exp = expected_dist_q.pop_front();
        if (rsp_if.seg_distance !== exp) report_mismatch("seg_distance", rsp_if.seg_distance, exp);
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.point_x = '0;
    req_if.point_y = '0;
    req_if.end1_x = '0;
    req_if.end1_y = '0;
    req_if.end2_x = '0;
    req_if.end2_y = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_segments();
    req_if.valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d queries, %0d with foot on segment, %0d results checked",
             n_sent, n_on_seg, n_checked);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/psd_pkg.sv
rtl/psd_in_if.sv
rtl/psd_out_if.sv
rtl/psd_prep.sv
rtl/psd_div.sv
rtl/psd_sqrt.sv
rtl/point_segment_distance.sv
test/point_segment_distance_tb.sv
